FILE: rtl/mpsm_pkg.sv
package mpsm_pkg;
   localparam int MaxNodesDef = 256;
   localparam int AlphabetDef = 256;
   localparam int MaxPatternsDef = 64;
   localparam int MaxPatLenDef = 32;
   localparam int MaxResults = 32;

   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_END = 2'd1;
   localparam logic [1:0] MODE_SCAN = 2'd2;
   localparam logic [1:0] MODE_RESTART = 2'd3;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_LONG = 2'd2;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] symbol;
   } req_type;

   typedef struct packed {
      logic        match_valid;
      logic [5:0]  pattern_id;
      logic [31:0] start_pos;
      logic [1:0]  status;
      logic        last;
   } rsp_type;
endpackage

FILE: rtl/mpsm_ram.sv
module mpsm_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: rtl/multi_pattern_string_matcher.sv
// channel   direction  ports
// req       in         start, busy, req_data (mode, symbol)
// rsp       out        rsp_strobe, rsp_data (match_valid, pattern_id, start_pos, status, last)
// after reset the child store and the terminal flags are cleared, one entry a cycle, over all
// 2**(node bits + symbol bits) child entries (65536 by default) while busy is high. a load
// raises busy through the LD states (a fault or overlong pattern answers from LD_RD); end and
// restart answer in the next cycle and never raise busy. a scan runs the SC states per
// goto/suffix walk read and the OUT states per output chain node. after reset or a load that
// adds a node, the next scan first rebuilds suffix links (RB states per queued node and
// symbol, FL states per suffix hop). results go out one per cycle at most; no receiver stall.
module multi_pattern_string_matcher
   import mpsm_pkg::*;
#(
   parameter int MAX_NODES = MaxNodesDef,
   parameter int ALPHABET_SIZE = AlphabetDef,
   parameter int MAX_PATTERNS = MaxPatternsDef,
   parameter int MAX_PATTERN_LEN = MaxPatLenDef
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);
   localparam int NW = $clog2(MAX_NODES);
   localparam int SW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
   localparam int PW = $clog2(MAX_PATTERNS) > 0 ? $clog2(MAX_PATTERNS) : 1;
   localparam int LW = $clog2(MAX_PATTERN_LEN + 1);
   localparam int CW = NW + SW;
   localparam int ChildDepth = 1 << CW;

   localparam logic [4:0] S_CLEAR = 5'd0, S_IDLE = 5'd1, S_LD_RD = 5'd2, S_LD_WT = 5'd3,
      S_LD_DO = 5'd4, S_SC_RD = 5'd5, S_SC_WT = 5'd6, S_SC_DO = 5'd7, S_SL_WT = 5'd8,
      S_SL_DO = 5'd9, S_OUT_RD = 5'd10, S_OUT_WT = 5'd11, S_OUT_DO = 5'd12,
      S_RB_POP = 5'd13, S_RB_RD = 5'd14, S_RB_WT = 5'd15, S_RB_DO = 5'd16,
      S_FL_RD = 5'd17, S_FL_WT = 5'd18, S_FL_DO = 5'd19, S_FL_SL = 5'd20, S_FL_SD = 5'd21,
      S_RB_SU = 5'd22, S_RB_SW = 5'd23;

   logic [4:0] state_ff, state_in;
   logic [CW-1:0] clr_ff, clr_in;
   logic [NW:0] node_count_ff, node_count_in;
   logic [PW:0] pat_count_ff, pat_count_in;
   logic [NW-1:0] ins_node_ff, ins_node_in;
   logic [LW-1:0] ins_depth_ff, ins_depth_in;
   logic [NW-1:0] scan_node_ff, scan_node_in;
   logic [31:0] pos_ff, pos_in;
   logic [1:0] fault_ff, fault_in;
   logic links_ok_ff, links_ok_in;
   req_type req_ff, req_in;
   logic [NW-1:0] x_ff, x_in;
   logic [NW:0] guard_ff, guard_in;
   logic [5:0] k_ff, k_in;
   logic [NW:0] head_ff, head_in, tail_ff, tail_in;
   logic [SW:0] sym_ff, sym_in;
   logic [NW-1:0] u_ff, u_in, w_ff, w_in, f_ff, f_in;
   logic [NW:0] fg_ff, fg_in;
   logic rsp_strobe_ff, rsp_strobe_in;
   rsp_type rsp_ff, rsp_in;
   rsp_type hold_ff, hold_in;

   // child store
   logic c_we; logic [CW-1:0] c_wa, c_ra; logic [NW-1:0] c_wd, c_rd;
   mpsm_ram #(.Width(NW), .Depth(ChildDepth)) u_child (
      .clock(clock), .wr_en(c_we), .wr_addr(c_wa), .wr_data(c_wd), .rd_addr(c_ra),
      .rd_data(c_rd));
   // suffix links
   logic l_we; logic [NW-1:0] l_wa, l_ra, l_wd, l_rd;
   mpsm_ram #(.Width(NW), .Depth(MAX_NODES)) u_link (
      .clock(clock), .wr_en(l_we), .wr_addr(l_wa), .wr_data(l_wd), .rd_addr(l_ra),
      .rd_data(l_rd));
   // node terminal flag (top bit) and pattern id
   logic p_we; logic [NW-1:0] p_wa, p_ra; logic [PW:0] p_wd, p_rd;
   mpsm_ram #(.Width(PW + 1), .Depth(MAX_NODES)) u_npat (
      .clock(clock), .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd), .rd_addr(p_ra),
      .rd_data(p_rd));
   // pattern lengths, read address follows node pattern read data
   logic g_we; logic [PW-1:0] g_wa; logic [LW-1:0] g_wd, g_rd;
   mpsm_ram #(.Width(LW), .Depth(MAX_PATTERNS)) u_plen (
      .clock(clock), .wr_en(g_we), .wr_addr(g_wa), .wr_data(g_wd), .rd_addr(p_rd[PW-1:0]),
      .rd_data(g_rd));
   // breadth-first queue
   logic q_we; logic [NW-1:0] q_wa, q_ra, q_wd, q_rd;
   mpsm_ram #(.Width(NW), .Depth(MAX_NODES)) u_queue (
      .clock(clock), .wr_en(q_we), .wr_addr(q_wa), .wr_data(q_wd), .rd_addr(q_ra),
      .rd_data(q_rd));

   // byte to symbol index, a constant table
   function automatic logic [SW-1:0] fold_symbol(input logic [7:0] b);
      logic [SW-1:0] r;
      r = '0;
      for (int v = 0; v < 256; v++) begin
         if (b == 8'(v)) r = SW'(v % ALPHABET_SIZE);
      end
      return r;
   endfunction

   logic [SW-1:0] sym_mod;
   assign sym_mod = fold_symbol(req_ff.symbol);

   assign busy = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data = rsp_ff;

   function automatic rsp_type mk(input logic v, input logic [5:0] id, input logic [31:0] sp,
                                  input logic [1:0] st, input logic l);
      rsp_type r;
      r.match_valid = v; r.pattern_id = id; r.start_pos = sp; r.status = st; r.last = l;
      return r;
   endfunction

   always_comb begin
      state_in = state_ff; clr_in = clr_ff; node_count_in = node_count_ff;
      pat_count_in = pat_count_ff; ins_node_in = ins_node_ff; ins_depth_in = ins_depth_ff;
      scan_node_in = scan_node_ff; pos_in = pos_ff; fault_in = fault_ff;
      links_ok_in = links_ok_ff; req_in = req_ff; x_in = x_ff;
      guard_in = guard_ff; k_in = k_ff; head_in = head_ff; tail_in = tail_ff; sym_in = sym_ff;
      u_in = u_ff; w_in = w_ff; f_in = f_ff; fg_in = fg_ff;
      rsp_strobe_in = 1'b0; rsp_in = rsp_ff; hold_in = hold_ff;
      c_we = 1'b0; c_wa = clr_ff; c_wd = '0; c_ra = '0;
      l_we = 1'b0; l_wa = '0; l_wd = '0; l_ra = '0;
      p_we = 1'b0; p_wa = '0; p_wd = '0; p_ra = '0;
      g_we = 1'b0; g_wa = '0; g_wd = '0;
      q_we = 1'b0; q_wa = '0; q_wd = '0; q_ra = '0;
      case (state_ff)
         S_CLEAR: begin
            c_we = 1'b1;
            if (clr_ff < CW'(MAX_NODES)) begin
               p_we = 1'b1; p_wa = clr_ff[NW-1:0]; p_wd = '0;
            end
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CW'(ChildDepth - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               req_in = req_data;
               case (req_data.mode)
                  MODE_LOAD: state_in = S_LD_RD;
                  MODE_END: begin
                     if (fault_ff != ST_OK) rsp_in = mk(1'b0, '0, '0, fault_ff, 1'b1);
                     else if (pat_count_ff >= (PW+1)'(MAX_PATTERNS))
                        rsp_in = mk(1'b0, '0, '0, ST_FULL, 1'b1);
                     else begin
                        p_we = 1'b1; p_wa = ins_node_ff; p_wd = {1'b1, pat_count_ff[PW-1:0]};
                        g_we = 1'b1; g_wa = pat_count_ff[PW-1:0]; g_wd = ins_depth_ff;
                        pat_count_in = pat_count_ff + 1'b1;
                        rsp_in = mk(1'b0, '0, '0, ST_OK, 1'b1);
                     end
                     ins_node_in = '0; ins_depth_in = '0; fault_in = ST_OK;
                     rsp_strobe_in = 1'b1;
                  end
                  MODE_RESTART: begin
                     scan_node_in = '0; pos_in = '0;
                     rsp_in = mk(1'b0, '0, '0, ST_OK, 1'b1);
                     rsp_strobe_in = 1'b1;
                  end
                  default: begin
                     if (!links_ok_ff) begin
                        // root's suffix link and the queue seed
                        l_we = 1'b1; l_wa = '0; l_wd = '0;
                        q_we = 1'b1; q_wa = '0; q_wd = '0;
                        head_in = '0; tail_in = (NW+1)'(1);
                        state_in = S_RB_POP;
                     end else begin
                        x_in = scan_node_ff; guard_in = '0;
                        state_in = S_SC_RD;
                     end
                  end
               endcase
            end
         end
         S_LD_RD: begin
            if (fault_ff != ST_OK) begin
               rsp_in = mk(1'b0, '0, '0, fault_ff, 1'b1); rsp_strobe_in = 1'b1;
               state_in = S_IDLE;
            end else if (ins_depth_ff >= LW'(MAX_PATTERN_LEN)) begin
               fault_in = ST_LONG;
               rsp_in = mk(1'b0, '0, '0, ST_LONG, 1'b1); rsp_strobe_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               c_ra = {ins_node_ff, sym_mod};
               state_in = S_LD_WT;
            end
         end
         S_LD_WT: begin
            c_ra = {ins_node_ff, sym_mod};
            state_in = S_LD_DO;
         end
         S_LD_DO: begin
            rsp_in = mk(1'b0, '0, '0, ST_OK, 1'b1); rsp_strobe_in = 1'b1;
            state_in = S_IDLE;
            if (c_rd != '0) begin
               ins_node_in = c_rd; ins_depth_in = ins_depth_ff + 1'b1;
            end else if (node_count_ff >= (NW+1)'(MAX_NODES)) begin
               fault_in = ST_FULL; rsp_in.status = ST_FULL;
            end else begin
               c_we = 1'b1; c_wa = {ins_node_ff, sym_mod}; c_wd = node_count_ff[NW-1:0];
               node_count_in = node_count_ff + 1'b1;
               links_ok_in = 1'b0;
               ins_node_in = node_count_ff[NW-1:0]; ins_depth_in = ins_depth_ff + 1'b1;
            end
         end
         // goto walk: x_ff current, read child, else suffix link
         S_SC_RD: begin
            c_ra = {x_ff, sym_mod}; l_ra = x_ff;
            state_in = S_SC_WT;
         end
         S_SC_WT: begin
            c_ra = {x_ff, sym_mod}; l_ra = x_ff;
            state_in = S_SC_DO;
         end
         S_SC_DO: begin
            if (x_ff == '0 || c_rd != '0 || guard_ff >= (NW+1)'(MAX_NODES)) begin
               if (x_ff == '0 || c_rd != '0) begin
                  scan_node_in = c_rd; x_in = c_rd;
                  guard_in = '0; k_in = '0;
                  state_in = S_OUT_RD;
               end else begin
                  // guard ran out: final read of child at x
                  state_in = S_SL_WT;
                  c_ra = {x_ff, sym_mod};
               end
            end else begin
               x_in = l_rd; guard_in = guard_ff + 1'b1;
               state_in = S_SC_RD;
            end
         end
         S_SL_WT: begin
            c_ra = {x_ff, sym_mod};
            state_in = S_SL_DO;
         end
         S_SL_DO: begin
            scan_node_in = c_rd; x_in = c_rd; guard_in = '0; k_in = '0;
            state_in = S_OUT_RD;
         end
         // output chain
         S_OUT_RD: begin
            if (x_ff == '0 || guard_ff >= (NW+1)'(MAX_NODES) || k_ff >= 6'(MaxResults)) begin
               if (k_ff == '0) begin
                  rsp_in = mk(1'b0, '0, '0, ST_OK, 1'b1); rsp_strobe_in = 1'b1;
               end else begin
                  // the held match is the final one
                  rsp_in = hold_ff; rsp_in.last = 1'b1; rsp_strobe_in = 1'b1;
               end
               pos_in = pos_ff + 1'b1;
               state_in = S_IDLE;
            end else begin
               p_ra = x_ff; l_ra = x_ff;
               state_in = S_OUT_WT;
            end
         end
         S_OUT_WT: begin
            p_ra = x_ff; l_ra = x_ff;
            state_in = S_OUT_DO;
         end
         S_OUT_DO: begin
            if (p_rd[PW]) begin
               // hold the newest match one step so the last one can be flagged
               if (k_ff != '0) begin
                  rsp_in = hold_ff; rsp_strobe_in = 1'b1;
               end
               hold_in = mk(1'b1, 6'(p_rd[PW-1:0]), pos_ff - 32'(g_rd) + 32'd1, ST_OK, 1'b0);
               k_in = k_ff + 1'b1;
            end
            x_in = l_rd; guard_in = guard_ff + 1'b1;
            state_in = S_OUT_RD;
         end
         // suffix link rebuild
         S_RB_POP: begin
            if (head_ff >= tail_ff) begin
               links_ok_in = 1'b1;
               x_in = scan_node_ff; guard_in = '0;
               state_in = S_SC_RD;
            end else begin
               q_ra = head_ff[NW-1:0];
               state_in = S_RB_SU;
            end
         end
         S_RB_SU: begin
            q_ra = head_ff[NW-1:0];
            state_in = S_RB_SW;
         end
         S_RB_SW: begin
            u_in = q_rd; l_ra = q_rd; sym_in = '0;
            head_in = head_ff + 1'b1;
            state_in = S_RB_RD;
         end
         S_RB_RD: begin
            if (sym_ff == (SW+1)'(ALPHABET_SIZE)) state_in = S_RB_POP;
            else begin
               c_ra = {u_ff, sym_ff[SW-1:0]}; l_ra = u_ff;
               state_in = S_RB_WT;
            end
         end
         S_RB_WT: begin
            c_ra = {u_ff, sym_ff[SW-1:0]}; l_ra = u_ff;
            state_in = S_RB_DO;
         end
         S_RB_DO: begin
            if (c_rd == '0 || tail_ff >= (NW+1)'(MAX_NODES)) begin
               sym_in = sym_ff + 1'b1; state_in = S_RB_RD;
            end else begin
               w_in = c_rd;
               q_we = 1'b1; q_wa = tail_ff[NW-1:0]; q_wd = c_rd;
               tail_in = tail_ff + 1'b1;
               if (u_ff == '0) begin
                  l_we = 1'b1; l_wa = c_rd; l_wd = '0;
                  sym_in = sym_ff + 1'b1; state_in = S_RB_RD;
               end else begin
                  f_in = l_rd; fg_in = '0;
                  state_in = S_FL_RD;
               end
            end
         end
         S_FL_RD: begin
            c_ra = {f_ff, sym_ff[SW-1:0]}; l_ra = f_ff;
            state_in = S_FL_WT;
         end
         S_FL_WT: begin
            c_ra = {f_ff, sym_ff[SW-1:0]}; l_ra = f_ff;
            state_in = S_FL_DO;
         end
         S_FL_DO: begin
            if (f_ff == '0 || c_rd != '0 || fg_ff >= (NW+1)'(MAX_NODES)) begin
               if (f_ff == '0 || c_rd != '0) begin
                  l_we = 1'b1; l_wa = w_ff; l_wd = c_rd;
                  sym_in = sym_ff + 1'b1; state_in = S_RB_RD;
               end else begin
                  c_ra = {f_ff, sym_ff[SW-1:0]};
                  state_in = S_FL_SL;
               end
            end else begin
               f_in = l_rd; fg_in = fg_ff + 1'b1;
               state_in = S_FL_RD;
            end
         end
         S_FL_SL: begin
            c_ra = {f_ff, sym_ff[SW-1:0]};
            state_in = S_FL_SD;
         end
         S_FL_SD: begin
            l_we = 1'b1; l_wa = w_ff; l_wd = c_rd;
            sym_in = sym_ff + 1'b1; state_in = S_RB_RD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; clr_ff <= '0; node_count_ff <= (NW+1)'(1);
         pat_count_ff <= '0; ins_node_ff <= '0; ins_depth_ff <= '0; scan_node_ff <= '0;
         pos_ff <= '0; fault_ff <= ST_OK; links_ok_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in; node_count_ff <= node_count_in;
         pat_count_ff <= pat_count_in; ins_node_ff <= ins_node_in;
         ins_depth_ff <= ins_depth_in; scan_node_ff <= scan_node_in; pos_ff <= pos_in;
         fault_ff <= fault_in; links_ok_ff <= links_ok_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      req_ff <= req_in; x_ff <= x_in; guard_ff <= guard_in; k_ff <= k_in;
      head_ff <= head_in; tail_ff <= tail_in; sym_ff <= sym_in; u_ff <= u_in;
      w_ff <= w_in; f_ff <= f_in; fg_ff <= fg_in; rsp_ff <= rsp_in; hold_ff <= hold_in;
   end
endmodule
